### rtl/sed_pkg.sv
// Shared types and constants for the sum-of-distances block.
// Used by sed_front, sed_isqrt and sum_of_euclidean_2d_distances.
`timescale 1ns / 1ps
`default_nettype none

package sed_pkg;

  localparam int CoordW = 16;
  localparam int AbsW   = 16;
  localparam int SqW    = 2 * AbsW;
  localparam int D2W    = SqW + 1;
  localparam int SumW   = 24;
  localparam int DistW  = 33;

  // Square root: two radicand bits per step.
  localparam int RootW    = (D2W + 1) / 2;
  localparam int RadW     = 2 * RootW;
  localparam int RemW     = RootW + 3;
  localparam int SqrtCntW = $clog2(RootW + 1);

  localparam int InDataW  = ((4 * CoordW + SumW) + 7) / 8 * 8;
  localparam int OutDataW = (DistW + 7) / 8 * 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_START,
    S_ROOT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic add;
  } front_ctl_t;

endpackage

`default_nettype wire

### rtl/sed_front.sv
// Front datapath: absolute coordinate differences, squares and their sum.
// Depends on sed_pkg; each stage advances on its own enable from the controller.
`timescale 1ns / 1ps
`default_nettype none

module sed_front (
  input  wire                          clk,
  input  wire  sed_pkg::front_ctl_t    ctl,
  input  wire  [sed_pkg::CoordW-1:0]   a_x,
  input  wire  [sed_pkg::CoordW-1:0]   a_y,
  input  wire  [sed_pkg::CoordW-1:0]   b_x,
  input  wire  [sed_pkg::CoordW-1:0]   b_y,
  output logic [sed_pkg::D2W-1:0]      d2
);
  import sed_pkg::*;

  logic [CoordW:0] dx;
  logic [CoordW:0] dy;
  logic [AbsW-1:0] adx_c;
  logic [AbsW-1:0] ady_c;
  logic [AbsW-1:0] adx;
  logic [AbsW-1:0] ady;
  logic [SqW-1:0]  sqx;
  logic [SqW-1:0]  sqy;

  // Sign-extend by one bit, the difference then never wraps.
  assign dx = {a_x[CoordW-1], a_x} - {b_x[CoordW-1], b_x};
  assign dy = {a_y[CoordW-1], a_y} - {b_y[CoordW-1], b_y};

  always_comb begin
    adx_c = dx[CoordW] ? AbsW'(-dx) : dx[AbsW-1:0];
    ady_c = dy[CoordW] ? AbsW'(-dy) : dy[AbsW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      adx <= adx_c;
      ady <= ady_c;
    end
    if (ctl.mul) begin
      sqx <= adx * adx;
      sqy <= ady * ady;
    end
    if (ctl.add) begin
      d2 <= {1'b0, sqx} + {1'b0, sqy};
    end
  end

endmodule

`default_nettype wire

### rtl/sed_isqrt.sv
// Digit-serial floor square root, one radix-4 digit of the radicand per cycle.
// Depends on sed_pkg for widths; busy stays high from start until all RootW digits are done.
`timescale 1ns / 1ps
`default_nettype none

module sed_isqrt (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  wire  [sed_pkg::D2W-1:0]    value,
  output logic                       busy,
  output logic [sed_pkg::RootW-1:0]  root
);
  import sed_pkg::*;

  logic [RadW-1:0]     rad;
  logic [RemW-1:0]     rem;
  logic [SqrtCntW-1:0] cnt;
  logic [RemW-1:0]     rem_sh;
  logic [RemW-1:0]     trial;
  logic                fits;

  // Bring in the next two radicand bits and try root*4+1.
  assign rem_sh = {rem[RemW-3:0], rad[RadW-1 -: 2]};
  assign trial  = RemW'({root, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= SqrtCntW'(RootW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == SqrtCntW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= RadW'(value);
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RadW-3:0], 2'b00};
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[RootW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

### rtl/sum_of_euclidean_2d_distances.sv
// Top level: stream ports, sequencing control, accumulator and result register.
// Depends on sed_pkg, sed_front and sed_isqrt.
//
// Usage: each request on the s_ channel carries one point pair of a vector;
// s_tlast marks the final pair and s_tuser enables the early exit against the
// limit field. The m_ channel returns at most one result per request: the
// vector sum of floor roots of dx^2+dy^2 (m_tuser = 1 when the sum passed the
// limit), or, with squared_mode set through cfg_we/cfg_wdata, dx^2+dy^2 of
// every single pair.
// Timing: one request at a time. A pair in sum mode passes from acceptance
// to the result register through 3 front stages, 17 square-root digit steps
// and the accumulate step; in squared mode it skips the root. The next
// request is taken once the controller is back in S_IDLE after the result
// write. Pairs dropped after an early exit are accepted in S_IDLE without
// starting the datapath. The 17-step root unit sets the rate.
// Reset clears the mode register, the running sum, the drop flag and the
// result valid flag. When m_tready is low the result holds in the output
// register; the next request is still accepted and computed, and only the
// step that writes a new result waits until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module sum_of_euclidean_2d_distances (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire                              cfg_wdata,   // squared_mode
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // a_x [15:0], a_y [31:16], b_x [47:32], b_y [63:48], limit [87:64]
  input  wire  [sed_pkg::InDataW-1:0]      s_tdata,
  input  wire                              s_tlast,     // last
  input  wire                              s_tuser,     // use_limit
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // distance [32:0], zero fill above
  output logic [sed_pkg::OutDataW-1:0]     m_tdata,
  output logic                             m_tuser      // exceeded
);
  import sed_pkg::*;

  state_t              state;
  state_t              state_next;
  front_ctl_t          fctl;
  logic                sqrt_start;
  logic                sqrt_busy;
  logic [RootW-1:0]    root;
  logic [D2W-1:0]      d2;

  logic                squared_mode;
  logic [SumW-1:0]     running_sum;
  logic                skipping;
  logic                last_q;
  logic                use_lim_q;
  logic [SumW-1:0]     limit_q;

  logic                accept;
  logic                drop;
  logic                out_free;
  logic [SumW:0]       sum_wide;
  logic [SumW-1:0]     sum_sat;
  logic                hit;
  logic                emit;
  logic                finish;

  assign accept   = s_tvalid && s_tready;
  assign drop     = !squared_mode && skipping;
  assign out_free = !m_tvalid || m_tready;

  assign sum_wide = {1'b0, running_sum} + (SumW + 1)'(root);
  assign sum_sat  = sum_wide[SumW] ? {SumW{1'b1}} : sum_wide[SumW-1:0];
  assign hit      = use_lim_q && (sum_sat > limit_q);
  assign emit     = squared_mode || hit || last_q;
  assign finish   = (state == S_DONE) && (!emit || out_free);

  sed_front u_front (
    .clk (clk),
    .ctl (fctl),
    .a_x (s_tdata[CoordW-1:0]),
    .a_y (s_tdata[2*CoordW-1:CoordW]),
    .b_x (s_tdata[3*CoordW-1:2*CoordW]),
    .b_y (s_tdata[4*CoordW-1:3*CoordW]),
    .d2  (d2)
  );

  sed_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (d2),
    .busy  (sqrt_busy),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    fctl       = '0;
    sqrt_start = 1'b0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && !drop) begin
          fctl.load  = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        fctl.mul   = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        fctl.add   = 1'b1;
        state_next = squared_mode ? S_DONE : S_START;
      end
      S_START: begin
        sqrt_start = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        if (!sqrt_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      squared_mode <= 1'b0;
      running_sum  <= '0;
      skipping     <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        squared_mode <= cfg_wdata;
      end
      // Drop the tail of a stopped vector; tlast ends the drop.
      if (accept && drop && s_tlast) begin
        skipping <= 1'b0;
      end
      if (finish && !squared_mode) begin
        if (hit) begin
          running_sum <= '0;
          skipping    <= !last_q;
        end else if (last_q) begin
          running_sum <= '0;
        end else begin
          running_sum <= sum_sat;
        end
      end
      if (finish && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !drop) begin
      last_q    <= s_tlast;
      use_lim_q <= s_tuser;
      limit_q   <= s_tdata[4*CoordW +: SumW];
    end
    if (finish && emit) begin
      if (squared_mode) begin
        m_tdata <= OutDataW'(d2);
        m_tuser <= 1'b0;
      end else begin
        m_tdata <= OutDataW'(sum_sat);
        m_tuser <= hit;
      end
    end
  end

endmodule

`default_nettype wire
